>>> design/gcr_pkg.sv
package gcr_pkg;

	localparam int FRAC = 24;

	localparam logic signed [33:0] FULL_TURN = 34'sd6039797760;
	localparam logic signed [32:0] QUARTER = 33'sd1509949440;
	localparam logic signed [32:0] HALF_QUARTER = 33'sd754974720;
	localparam logic [33:0] PI_Q32 = 34'h3243F6A88;
	localparam logic [32:0] RECIP_180 = 33'((65'd1 << 40) / 65'd180);
	localparam logic [32:0] RECIP_1000 = 33'((65'd1 << 42) / 65'd1000);
	localparam logic [31:0] GAIN_Q32 = 32'h9B74EDA8;
	localparam logic signed [25:0] GAIN_QF =
		26'((33'(GAIN_Q32) + (33'd1 << (31 - FRAC))) >> (32 - FRAC));
	localparam logic signed [25:0] ONE_QF = 26'sd1 <<< FRAC;
	localparam logic [30:0] RADIUS_MILLI_X512 = 31'd1761313280;
	localparam logic [32:0] HALF_THOUSAND_QF = 33'd500 << FRAC;
	localparam logic [21:0] DIST_MAX = 22'd2766680;
	localparam logic [21:0] RADIUS_RESET = 22'd38400;
	localparam int LAT = 85;

	localparam logic [29:0] ATAN_Q30 [0:10] = '{
		30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159, 30'd67021687,
		30'd33543516, 30'd16775851, 30'd8388437, 30'd4194283, 30'd2097149,
		30'd1048576
	};

	function automatic logic signed [26:0] atan_q(input int i);
		logic [30:0] t;
		begin
			if (i <= 10) begin
				t = (31'(ATAN_Q30[i]) + (31'd1 << (29 - FRAC))) >> (30 - FRAC);
				atan_q = 27'(t);
			end else begin
				atan_q = 27'sd1 <<< (FRAC - i);
			end
		end
	endfunction

	function automatic logic signed [25:0] clamp_unit(input logic signed [25:0] v);
		begin
			if (v > ONE_QF) clamp_unit = ONE_QF;
			else if (v < -ONE_QF) clamp_unit = -ONE_QF;
			else clamp_unit = v;
		end
	endfunction

	function automatic logic signed [25:0] fxmul(input logic signed [25:0] a,
		input logic signed [25:0] b);
		logic [24:0] ua;
		logic [24:0] ub;
		logic [49:0] p;
		logic signed [25:0] m;
		begin
			ua = a[25] ? 25'(-a) : 25'(a);
			ub = b[25] ? 25'(-b) : 25'(b);
			p = 50'(ua) * 50'(ub);
			m = $signed({1'b0, p[48:24]});
			fxmul = (a[25] != b[25]) ? -m : m;
		end
	endfunction

endpackage

>>> design/gcr_if.sv
interface gcr_pair_if;
	logic valid;
	logic ready;
	logic signed [30:0] first_latitude;
	logic signed [31:0] first_longitude;
	logic signed [30:0] second_latitude;
	logic signed [31:0] second_longitude;

	modport source(output valid, first_latitude, first_longitude, second_latitude,
		second_longitude, input ready);
	modport sink(input valid, first_latitude, first_longitude, second_latitude,
		second_longitude, output ready);
endinterface

interface gcr_result_if;
	logic valid;
	logic ready;
	logic [21:0] distance;
	logic within_res;

	modport source(output valid, distance, within_res, input ready);
	modport sink(input valid, distance, within_res, output ready);
endinterface

>>> design/great_circle_radius_check.sv
// One word is accepted every cycle unless stalled; all stages advance together and hold while
// a finished result waits at the output register.
// Reset clears all valid bits and sets the radius register to 38400.
module great_circle_radius_check import gcr_pkg::*; (
	input logic clk,
	input logic arst_n,
	gcr_pair_if.sink pair,
	gcr_result_if.source result,
	input logic radius_we,
	input logic [21:0] radius_wdata
);

	logic en;
	logic [LAT-1:0] vld_q;
	logic [21:0] radius_q;

	logic signed [32:0] dlat_s1;
	logic signed [32:0] dlon_s1;
	logic signed [32:0] lat1_s1;
	logic signed [32:0] lat2_s1;

	logic signed [25:0] sa, ca, sb, cb, s1, c1, s2, c2;

	logic signed [25:0] sa2_m1;
	logic signed [25:0] cc_m1;
	logic signed [25:0] sb2_m1;
	logic signed [25:0] sa2_m2;
	logic signed [25:0] t_m2;
	logic signed [26:0] hsum;
	logic [24:0] hav;

	logic [46:0] yv_s [0:24];
	logic [47:0] yr_s [0:24];
	logic [46:0] xv_s [0:24];
	logic [47:0] xr_s [0:24];

	logic signed [26:0] vx_s [1:24];
	logic signed [26:0] vy_s [1:24];
	logic signed [26:0] vz_s [1:24];

	logic [25:0] zc;
	logic [57:0] dprod;
	logic [32:0] dn_d1;
	logic [65:0] dprod_rcp;
	logic [32:0] dn_d2;
	logic [23:0] dest_d2;
	logic [32:0] drr;
	logic [24:0] dist_rnd;
	logic [21:0] dist_sat;

	assign en = !vld_q[LAT-1] || result.ready;
	assign pair.ready = en;
	assign result.valid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			radius_q <= RADIUS_RESET;
		end else begin
			if (en) vld_q <= {vld_q[LAT-2:0], pair.valid};
			if (radius_we) radius_q <= radius_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dlat_s1 <= 33'(pair.second_latitude) - 33'(pair.first_latitude);
			dlon_s1 <= 33'(pair.second_longitude) - 33'(pair.first_longitude);
			lat1_s1 <= 33'(pair.first_latitude) <<< 1;
			lat2_s1 <= 33'(pair.second_latitude) <<< 1;
		end
	end

	gcr_trig u_trig_dlat (.clk, .en, .arg(dlat_s1), .sin_val(sa), .cos_val(ca));
	gcr_trig u_trig_dlon (.clk, .en, .arg(dlon_s1), .sin_val(sb), .cos_val(cb));
	gcr_trig u_trig_lat1 (.clk, .en, .arg(lat1_s1), .sin_val(s1), .cos_val(c1));
	gcr_trig u_trig_lat2 (.clk, .en, .arg(lat2_s1), .sin_val(s2), .cos_val(c2));

	always_comb begin
		hsum = 27'(sa2_m2) + 27'(t_m2);
		if (hsum < 0) hav = '0;
		else if (hsum > 27'(ONE_QF)) hav = 25'(ONE_QF);
		else hav = 25'(hsum);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sa2_m1 <= fxmul(sa, sa);
			cc_m1 <= fxmul(c1, c2);
			sb2_m1 <= fxmul(sb, sb);
			sa2_m2 <= sa2_m1;
			t_m2 <= fxmul(cc_m1, sb2_m1);
			yv_s[0] <= 47'(hav) << (FRAC - 2);
			yr_s[0] <= '0;
			xv_s[0] <= 47'(25'(ONE_QF) - hav) << (FRAC - 2);
			xr_s[0] <= '0;
		end
	end

	for (genvar k = 0; k < FRAC; k++) begin : g_sqrt
		localparam logic [47:0] BIT = 48'd1 << (2 * (FRAC - 1 - k));
		logic [47:0] ytry;
		logic [47:0] xtry;
		assign ytry = yr_s[k] + BIT;
		assign xtry = xr_s[k] + BIT;
		always_ff @(posedge clk) begin
			if (en) begin
				if (48'(yv_s[k]) >= ytry) begin
					yv_s[k + 1] <= yv_s[k] - 47'(ytry);
					yr_s[k + 1] <= (yr_s[k] >> 1) + BIT;
				end else begin
					yv_s[k + 1] <= yv_s[k];
					yr_s[k + 1] <= yr_s[k] >> 1;
				end
				if (48'(xv_s[k]) >= xtry) begin
					xv_s[k + 1] <= xv_s[k] - 47'(xtry);
					xr_s[k + 1] <= (xr_s[k] >> 1) + BIT;
				end else begin
					xv_s[k + 1] <= xv_s[k];
					xr_s[k + 1] <= xr_s[k] >> 1;
				end
			end
		end
	end

	for (genvar i = 0; i < FRAC; i++) begin : g_vec
		logic signed [26:0] xi;
		logic signed [26:0] yi;
		logic signed [26:0] zi;
		logic signed [26:0] xs;
		logic signed [26:0] ys;
		logic signed [26:0] step;
		if (i == 0) begin : g_first
			assign xi = $signed({3'b000, xr_s[FRAC][23:0]});
			assign yi = $signed({3'b000, yr_s[FRAC][23:0]});
			assign zi = '0;
		end else begin : g_next
			assign xi = vx_s[i];
			assign yi = vy_s[i];
			assign zi = vz_s[i];
		end
		assign xs = xi >>> i;
		assign ys = yi >>> i;
		assign step = atan_q(i);
		always_ff @(posedge clk) begin
			if (en) begin
				if (yi > 0) begin
					vx_s[i + 1] <= xi + ys;
					vy_s[i + 1] <= yi - xs;
					vz_s[i + 1] <= zi + step;
				end else begin
					vx_s[i + 1] <= xi - ys;
					vy_s[i + 1] <= yi + xs;
					vz_s[i + 1] <= zi - step;
				end
			end
		end
	end

	always_comb begin
		zc = vz_s[FRAC][26] ? '0 : vz_s[FRAC][25:0];
		dprod = 58'(zc) * 58'(RADIUS_MILLI_X512) + 58'(HALF_THOUSAND_QF);
		dprod_rcp = 66'(dn_d1) * 66'(RECIP_1000);
		drr = dn_d2 - 33'(dest_d2) * 33'd1000;
		dist_rnd = (drr >= 33'd1000) ? 25'(dest_d2) + 25'd1 : 25'(dest_d2);
		dist_sat = (dist_rnd > 25'(DIST_MAX)) ? DIST_MAX : dist_rnd[21:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dn_d1 <= dprod[56:24];
			dn_d2 <= dn_d1;
			dest_d2 <= dprod_rcp[65:42];
			result.distance <= dist_sat;
			result.within_res <= (dist_sat <= radius_q);
		end
	end

endmodule

>>> design/gcr_trig.sv
module gcr_trig import gcr_pkg::*; (
	input logic clk,
	input logic en,
	input logic signed [32:0] arg,
	output logic signed [25:0] sin_val,
	output logic signed [25:0] cos_val
);

	logic signed [33:0] wrap_s1;
	logic [1:0] quad_s2;
	logic neg_s2;
	logic [29:0] mag_s2;
	logic [1:0] quad_s3;
	logic neg_s3;
	logic [31:0] num_s3;
	logic [1:0] quad_s4;
	logic neg_s4;
	logic [31:0] num_s4;
	logic [24:0] est_s4;

	logic signed [33:0] shifted;
	logic [2:0] qsel;
	logic signed [33:0] base;
	logic signed [33:0] rem;
	logic [63:0] prod_pi;
	logic [64:0] prod_rcp;
	logic [32:0] rr;
	logic [24:0] zmag;

	logic signed [25:0] cx_s [0:24];
	logic signed [25:0] cy_s [0:24];
	logic signed [25:0] cz_s [0:24];
	logic [1:0] cq_s [0:24];

	logic signed [25:0] rx;
	logic signed [25:0] ry;

	always_comb begin
		shifted = wrap_s1 + HALF_QUARTER;
		if (shifted >= 4 * QUARTER) qsel = 3'd4;
		else if (shifted >= 3 * QUARTER) qsel = 3'd3;
		else if (shifted >= 2 * QUARTER) qsel = 3'd2;
		else if (shifted >= QUARTER) qsel = 3'd1;
		else qsel = 3'd0;
		base = 34'(qsel) * 34'(QUARTER);
		rem = wrap_s1 - base;
		prod_pi = 64'(mag_s2) * 64'(PI_Q32);
		prod_rcp = 65'(num_s3) * 65'(RECIP_180);
		rr = 33'(num_s4) - 33'(est_s4) * 33'd180;
		zmag = (rr >= 33'd180) ? est_s4 + 25'd1 : est_s4;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			wrap_s1 <= arg[32] ? 34'(arg) + FULL_TURN : 34'(arg);
			quad_s2 <= qsel[1:0];
			neg_s2 <= rem[33];
			mag_s2 <= rem[33] ? 30'(-rem) : 30'(rem);
			quad_s3 <= quad_s2;
			neg_s3 <= neg_s2;
			num_s3 <= prod_pi[63:32];
			quad_s4 <= quad_s3;
			neg_s4 <= neg_s3;
			num_s4 <= num_s3;
			est_s4 <= prod_rcp[64:40];
			cx_s[0] <= GAIN_QF;
			cy_s[0] <= '0;
			cz_s[0] <= neg_s4 ? -$signed({1'b0, zmag}) : $signed({1'b0, zmag});
			cq_s[0] <= quad_s4;
		end
	end

	for (genvar i = 0; i < FRAC; i++) begin : g_rot
		logic signed [25:0] xs;
		logic signed [25:0] ys;
		logic signed [25:0] step;
		assign xs = cx_s[i] >>> i;
		assign ys = cy_s[i] >>> i;
		assign step = 26'(atan_q(i));
		always_ff @(posedge clk) begin
			if (en) begin
				if (cz_s[i] >= 0) begin
					cx_s[i + 1] <= cx_s[i] - ys;
					cy_s[i + 1] <= cy_s[i] + xs;
					cz_s[i + 1] <= cz_s[i] - step;
				end else begin
					cx_s[i + 1] <= cx_s[i] + ys;
					cy_s[i + 1] <= cy_s[i] - xs;
					cz_s[i + 1] <= cz_s[i] + step;
				end
				cq_s[i + 1] <= cq_s[i];
			end
		end
	end

	always_comb begin
		unique case (cq_s[FRAC])
			2'd0: begin rx = cx_s[FRAC]; ry = cy_s[FRAC]; end
			2'd1: begin rx = -cy_s[FRAC]; ry = cx_s[FRAC]; end
			2'd2: begin rx = -cx_s[FRAC]; ry = -cy_s[FRAC]; end
			default: begin rx = cy_s[FRAC]; ry = -cx_s[FRAC]; end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sin_val <= clamp_unit(ry);
			cos_val <= clamp_unit(rx);
		end
	end

endmodule

>>> verif/great_circle_radius_check_monitor.sv
module great_circle_radius_check_monitor import gcr_pkg::*; (
	input logic clk,
	input logic arst_n,
	gcr_pair_if.sink pair,
	gcr_result_if.sink result,
	input logic radius_we,
	input logic [21:0] radius_wdata,
	output int fail_count,
	output int pending_count,
	output int words_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int F = 24;

	typedef struct packed {
		logic [21:0] distance;
		logic within_res;
	} range_word_t;

	range_word_t expected_ranges[$];
	logic [21:0] radius_model;

	function automatic longint shift_down(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint arc_step(int i);
		longint q30[0:10];
		q30 = '{843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
			16775851, 8388437, 4194283, 2097149, 1048576};
		if (i <= 10) begin
			return (q30[i] + (64'sd1 << (29 - F))) >>> (30 - F);
		end
		return 64'sd1 << (F - i);
	endfunction

	function automatic longint unit_clip(longint v);
		longint one;
		one = 64'sd1 << F;
		if (v > one) return one;
		if (v < -one) return -one;
		return v;
	endfunction

	function automatic longint frac_product(longint a, longint b);
		logic [63:0] ua;
		logic [63:0] ub;
		logic [63:0] t;
		longint p;
		ua = a < 0 ? -a : a;
		ub = b < 0 ? -b : b;
		t = (ua >> 16) * ub + (((ua & 64'hFFFF) * ub) >> 16);
		p = longint'(t >> (F - 16));
		return ((a < 0) != (b < 0)) ? -p : p;
	endfunction

	task automatic sin_cos(input longint u, output longint s, output longint c);
		longint full;
		longint quarter;
		longint r;
		longint rem;
		longint x;
		longint y;
		longint z;
		longint t;
		longint xs;
		longint ys;
		logic [127:0] wide;
		int q;
		full = 64'sd360 << 24;
		quarter = 64'sd90 << 24;
		r = u % full;
		if (r < 0) r += full;
		q = int'(r / quarter);
		rem = r - longint'(q) * quarter;
		if (rem >= quarter / 2) begin
			q++;
			rem -= quarter;
		end
		wide = 128'(rem < 0 ? -rem : rem) * 128'h3243F6A88;
		z = longint'(wide / (128'd180 << (56 - F)));
		if (rem < 0) z = -z;
		x = longint'((64'h9B74EDA8 + ((64'd1 << (32 - F)) >> 1)) >> (32 - F));
		y = 0;
		for (int i = 0; i < F; i++) begin
			xs = shift_down(x, i);
			ys = shift_down(y, i);
			if (z >= 0) begin
				x -= ys; y += xs; z -= arc_step(i);
			end else begin
				x += ys; y -= xs; z += arc_step(i);
			end
		end
		case (q & 3)
			0: ;
			1: begin t = x; x = -y; y = t; end
			2: begin x = -x; y = -y; end
			default: begin t = x; x = y; y = -t; end
		endcase
		s = unit_clip(y);
		c = unit_clip(x);
	endtask

	function automatic longint int_root(logic [63:0] v);
		logic [63:0] res;
		logic [63:0] b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return longint'(res);
	endfunction

	task automatic predict_range(input longint lat1, input longint lon1, input longint lat2,
		input longint lon2, output range_word_t w);
		longint sa, ca, sb, cb, s1, c1, s2, c2, a, x, y, z, xs, ys, one;
		logic [63:0] num;
		logic [63:0] dist_nm;
		one = 64'sd1 << F;
		sin_cos(lat2 - lat1, sa, ca);
		sin_cos(lon2 - lon1, sb, cb);
		sin_cos(2 * lat1, s1, c1);
		sin_cos(2 * lat2, s2, c2);
		a = frac_product(sa, sa) + frac_product(frac_product(c1, c2), frac_product(sb, sb));
		if (a < 0) a = 0;
		if (a > one) a = one;
		y = int_root(64'(a) << (F - 2));
		x = int_root(64'(one - a) << (F - 2));
		z = 0;
		for (int i = 0; i < F; i++) begin
			xs = shift_down(x, i);
			ys = shift_down(y, i);
			if (y > 0) begin
				x += ys; y -= xs; z += arc_step(i);
			end else begin
				x -= ys; y += xs; z -= arc_step(i);
			end
		end
		if (z < 0) z = 0;
		num = 64'(z) * (64'd3440065 * 64'd512) + (64'd500 << F);
		dist_nm = num / (64'd1000 << F);
		if (dist_nm > 64'(DIST_MAX)) dist_nm = 64'(DIST_MAX);
		w.distance = dist_nm[21:0];
		w.within_res = dist_nm <= 64'(radius_model);
	endtask

	always @(posedge clk or negedge arst_n) begin
		range_word_t w;
		range_word_t e;
		if (!arst_n) begin
			radius_model <= RADIUS_RESET;
			fail_count <= 0;
			words_seen <= 0;
			expected_ranges.delete();
		end else begin
			if (pair.valid && pair.ready) begin
				predict_range(pair.first_latitude, pair.first_longitude,
					pair.second_latitude, pair.second_longitude, w);
				expected_ranges.insert(expected_ranges.size(), w);
			end
			if (result.valid && result.ready) begin
				words_seen <= words_seen + 1;
				if (expected_ranges.size() == 0) begin
					if (fail_count < 10) $display("Unexpected result word %0d/%0b",
						result.distance, result.within_res);
					fail_count <= fail_count + 1;
				end else begin
					e = expected_ranges.pop_front();
					if (e.distance !== result.distance || e.within_res !== result.within_res) begin
						if (fail_count < 10) $display(
							"Mismatch: expected %0d/%0b, got %0d/%0b", e.distance,
							e.within_res, result.distance, result.within_res);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (radius_we) radius_model <= radius_wdata;
		end
	end

	assign pending_count = expected_ranges.size();
endmodule

>>> verif/great_circle_radius_check_tb.sv
module great_circle_radius_check_tb;
	import gcr_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LAT_MAX = 754974720;
	localparam int LON_MAX = 1509949440;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic radius_we = 1'b0;
	logic [21:0] radius_wdata = '0;
	int fail_count;
	int pending_count;
	int words_seen;
	int hold_cycles = 0;
	int pairs_sent = 0;
	bit stim_done = 1'b0;

	gcr_pair_if pair();
	gcr_result_if result();

	great_circle_radius_check i_dut(.clk(clk), .arst_n(arst_n), .pair(pair), .result(result),
		.radius_we(radius_we), .radius_wdata(radius_wdata));

	great_circle_radius_check_monitor i_monitor(.clk(clk), .arst_n(arst_n), .pair(pair),
		.result(result), .radius_we(radius_we), .radius_wdata(radius_wdata),
		.fail_count(fail_count), .pending_count(pending_count), .words_seen(words_seen));

	always #4 clk = ~clk;

	initial begin
		pair.valid = 1'b0;
		pair.first_latitude = '0;
		pair.first_longitude = '0;
		pair.second_latitude = '0;
		pair.second_longitude = '0;
		result.ready = 1'b0;
	end

	task automatic send_pair(input int lat1, input int lon1, input int lat2, input int lon2,
		input bit gaps);
		int wait_cycles;
		wait_cycles = gaps ? $urandom_range(0, 8) : 0;
		if (wait_cycles > 0) begin
			pair.valid <= 1'b0;
			repeat (wait_cycles) @(negedge clk);
		end
		pair.valid <= 1'b1;
		pair.first_latitude <= 31'(lat1);
		pair.first_longitude <= lon1;
		pair.second_latitude <= 31'(lat2);
		pair.second_longitude <= lon2;
		do @(posedge clk); while (!pair.ready);
		pairs_sent++;
		@(negedge clk);
	endtask

	task automatic drain_and_set(input logic [21:0] r);
		pair.valid <= 1'b0;
		while (pending_count != 0) @(negedge clk);
		repeat (LAT + 5) @(negedge clk);
		radius_we <= 1'b1;
		radius_wdata <= r;
		@(negedge clk);
		radius_we <= 1'b0;
	endtask

	function automatic int any_lat();
		return $urandom_range(0, 3) == 0 ? int'($urandom_range(0, 2 * 1073741823) - 1073741824)
			: int'($urandom_range(0, 2 * LAT_MAX)) - LAT_MAX;
	endfunction

	function automatic int any_lon();
		return $urandom_range(0, 3) == 0 ? int'($urandom())
			: int'($urandom_range(0, 2 * LON_MAX)) - LON_MAX;
	endfunction

	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			result.ready <= 1'b0;
		end else if (result.valid && result.ready) begin
			if ($urandom_range(0, 3) == 0) hold_cycles <= $urandom_range(1, 8);
			else result.ready <= 1'b1;
		end else begin
			result.ready <= stim_done || ($urandom_range(0, 4) != 0);
		end
	end

	initial begin
		int lat1;
		int lon1;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		send_pair(0, 0, 0, 0, 1'b0);
		send_pair(LAT_MAX, LON_MAX, -LAT_MAX, -LON_MAX, 1'b0);
		send_pair(-LAT_MAX, 0, LAT_MAX, 0, 1'b0);
		send_pair(0, -LON_MAX, 0, LON_MAX, 1'b0);
		send_pair(-1073741824, 32'sh80000000, 1073741823, 2147483647, 1'b0);
		send_pair(1073741823, 2147483647, -1073741824, 32'sh80000000, 1'b0);
		send_pair(LAT_MAX, 0, LAT_MAX, LON_MAX, 1'b0);
		send_pair(0, 0, 0, 1 << 23, 1'b0);
		send_pair(100, 200, 100, 200, 1'b0);
		send_pair(0, 0, 0, 19, 1'b0);
		send_pair(0, 0, 37748736, 0, 1'b0);
		send_pair(-37748736, 0, 37748736, 0, 1'b0);
		drain_and_set(22'd0);
		send_pair(0, 0, 0, 0, 1'b0);
		send_pair(0, 0, 0, 1, 1'b0);
		send_pair(0, 0, 0, 1 << 23, 1'b0);
		drain_and_set(22'h3FFFFF);
		send_pair(-LAT_MAX, -LON_MAX, LAT_MAX, LON_MAX, 1'b0);
		send_pair(0, 0, 0, LON_MAX, 1'b0);
		drain_and_set(22'd15360);
		hold_cycles = 300;
		for (int i = 0; i < 200; i++) send_pair(any_lat(), any_lon(), any_lat(), any_lon(), 1'b0);
		pair.valid <= 1'b0;
		while (pending_count != 0) @(negedge clk);
		for (int phase = 0; phase < 4; phase++) begin
			for (int i = 0; i < 260; i++) begin
				lat1 = any_lat();
				lon1 = any_lon();
				if ($urandom_range(0, 1))
					send_pair(lat1, lon1, lat1 + int'($urandom_range(0, 8000000)) - 4000000,
						lon1 + int'($urandom_range(0, 8000000)) - 4000000, $urandom_range(0, 3) != 0);
				else
					send_pair(lat1, lon1, any_lat(), any_lon(), $urandom_range(0, 3) != 0);
			end
			drain_and_set(phase == 3 ? RADIUS_RESET : 22'($urandom_range(0, 4194303)));
		end
		stim_done = 1'b1;
		while (pending_count != 0) @(negedge clk);
		repeat (LAT + 10) @(negedge clk);
		$display("Sent %0d position pairs over seven radius settings, %0d results checked.",
			pairs_sent, words_seen);
		if (fail_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	initial begin
		#5ms;
		$display("RESULT: ERROR");
		$finish;
	end
endmodule

>>> files.f
design/gcr_pkg.sv
design/gcr_if.sv
design/gcr_trig.sv
design/great_circle_radius_check.sv
verif/great_circle_radius_check_monitor.sv
verif/great_circle_radius_check_tb.sv
